// File: hdl/chunked_size_line_parser_core_defines.svh
// Assertion macros for the chunk size line parser.
`ifndef CHUNKED_SIZE_LINE_PARSER_CORE_DEFINES_SVH
`define CHUNKED_SIZE_LINE_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CSLP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define CSLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CSLP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`define CSLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/cslp_pkg.sv
package cslp_pkg;

  localparam int unsigned MAX_SIZE_DIGITS_DEF = 12;
  localparam int unsigned LENGTH_BITS_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  localparam int unsigned SIZE_W     = 48;
  localparam int unsigned LINE_LEN_W = 16;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [7:0] CHAR_HTAB = 8'h09;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UF   = 8'h46;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LF_F = 8'h66;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA    = 2'd0,
    ST_FINAL   = 2'd1,
    ST_TRAILER = 2'd2,
    ST_FAILED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CL_HEX,
    CL_CR,
    CL_LF,
    CL_BAD,
    CL_TEXT
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] hval;
  } tok_t;

endpackage

// File: hdl/cslp_front.sv
module cslp_front (
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output cslp_pkg::tok_t   tok_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    tok_o.cls  = cslp_pkg::CL_TEXT;
    tok_o.hval = '0;
    if (in_byte_i >= cslp_pkg::CHAR_0 && in_byte_i <= cslp_pkg::CHAR_9) begin
      tok_o.cls  = cslp_pkg::CL_HEX;
      tok_o.hval = 4'(in_byte_i - cslp_pkg::CHAR_0);
    end else if (in_byte_i >= cslp_pkg::CHAR_UA && in_byte_i <= cslp_pkg::CHAR_UF) begin
      tok_o.cls  = cslp_pkg::CL_HEX;
      tok_o.hval = 4'(in_byte_i - cslp_pkg::CHAR_UA + 8'd10);
    end else if (in_byte_i >= cslp_pkg::CHAR_LA && in_byte_i <= cslp_pkg::CHAR_LF_F) begin
      tok_o.cls  = cslp_pkg::CL_HEX;
      tok_o.hval = 4'(in_byte_i - cslp_pkg::CHAR_LA + 8'd10);
    end else if (in_byte_i == cslp_pkg::CHAR_CR) begin
      tok_o.cls = cslp_pkg::CL_CR;
    end else if (in_byte_i == cslp_pkg::CHAR_LF) begin
      tok_o.cls = cslp_pkg::CL_LF;
    end else if ((in_byte_i < cslp_pkg::CHAR_SP && in_byte_i != cslp_pkg::CHAR_HTAB) ||
                 in_byte_i == cslp_pkg::CHAR_DEL) begin
      tok_o.cls = cslp_pkg::CL_BAD;
    end
  end

endmodule

// File: hdl/cslp_queue.sv
module cslp_queue #(
  parameter int unsigned DEPTH = cslp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cslp_pkg::tok_t tok_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cslp_pkg::tok_t tok_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cslp_pkg::tok_t  mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// File: hdl/cslp_back.sv
module cslp_back #(
  parameter int unsigned MAX_SIZE_DIGITS = cslp_pkg::MAX_SIZE_DIGITS_DEF,
  parameter int unsigned LENGTH_BITS     = cslp_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tok_valid_i,
  input  cslp_pkg::tok_t                  tok_i,
  output logic                            pop_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [cslp_pkg::STATUS_W-1:0]   status_o,
  output logic [cslp_pkg::SIZE_W-1:0]     chunk_size_o,
  output logic [cslp_pkg::LINE_LEN_W-1:0] line_length_o
);

  localparam int unsigned DCW = $clog2(MAX_SIZE_DIGITS + 1);
  localparam int unsigned LB  = LENGTH_BITS;
  localparam int unsigned SW  = cslp_pkg::SIZE_W;
  localparam int unsigned OLW = cslp_pkg::LINE_LEN_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIGITS,
    PH_EXT,
    PH_CR,
    PH_LOOK1,
    PH_LOOK2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [DCW-1:0]      cnt_q, cnt_d;
  logic [SW-1:0]       acc_q, acc_d;
  logic [LB-1:0]       len_q, len_d;
  logic                look_q, look_d;
  logic                out_valid_q, out_valid_d;
  cslp_pkg::status_e   status_q, status_d;
  logic [SW-1:0]       size_q, size_d;
  logic [OLW-1:0]      olen_q, olen_d;

  logic                pop;
  logic                ext_step;
  logic                emit;
  cslp_pkg::status_e   emit_st;
  logic [SW-1:0]       emit_size;
  logic [LB-1:0]       emit_len;
  logic [LB:0]         len_p1, len_p2;
  logic [LB-1:0]       len_sat1, len_sat2;
  logic                is_hex;

  assign pop    = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o  = pop;
  assign is_hex = (tok_i.cls == cslp_pkg::CL_HEX);

  assign len_p1   = {1'b0, len_q} + (LB + 1)'(1);
  assign len_p2   = {1'b0, len_q} + (LB + 1)'(2);
  assign len_sat1 = len_p1[LB] ? '1 : len_p1[LB-1:0];
  assign len_sat2 = len_p2[LB] ? '1 : len_p2[LB-1:0];

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    len_d       = len_q;
    look_d      = look_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    size_d      = size_q;
    olen_d      = olen_q;
    ext_step    = 1'b0;
    emit        = 1'b0;
    emit_st     = cslp_pkg::ST_FAILED;
    emit_size   = '0;
    emit_len    = '0;
    if (pop) begin
      case (phase_q)
        PH_IDLE: begin
          if (is_hex) begin
            acc_d   = SW'(tok_i.hval);
            cnt_d   = DCW'(1);
            len_d   = LB'(1);
            phase_d = PH_DIGITS;
          end else begin
            emit = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_hex) begin
            if (cnt_q >= DCW'(MAX_SIZE_DIGITS)) begin
              emit = 1'b1;
            end else begin
              acc_d = {acc_q[SW-5:0], tok_i.hval};
              cnt_d = cnt_q + DCW'(1);
              len_d = len_sat1;
            end
          end else begin
            ext_step = 1'b1;
          end
        end
        PH_EXT: begin
          ext_step = 1'b1;
        end
        PH_CR: begin
          if (tok_i.cls == cslp_pkg::CL_LF) begin
            if (acc_q != '0) begin
              emit      = 1'b1;
              emit_st   = cslp_pkg::ST_DATA;
              emit_size = acc_q;
              emit_len  = len_sat1;
            end else begin
              len_d   = len_sat1;
              phase_d = PH_LOOK1;
            end
          end else begin
            emit = 1'b1;
          end
        end
        PH_LOOK1: begin
          look_d  = (tok_i.cls == cslp_pkg::CL_CR);
          phase_d = PH_LOOK2;
        end
        PH_LOOK2: begin
          emit = 1'b1;
          if (look_q && tok_i.cls == cslp_pkg::CL_LF) begin
            emit_st  = cslp_pkg::ST_FINAL;
            emit_len = len_sat2;
          end else begin
            emit_st  = cslp_pkg::ST_TRAILER;
            emit_len = len_q;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          acc_d   = '0;
          len_d   = '0;
          look_d  = 1'b0;
        end
      endcase
      if (ext_step) begin
        if (tok_i.cls == cslp_pkg::CL_CR) begin
          len_d   = len_sat1;
          phase_d = PH_CR;
        end else if (tok_i.cls == cslp_pkg::CL_BAD || tok_i.cls == cslp_pkg::CL_LF) begin
          emit = 1'b1;
        end else begin
          len_d   = len_sat1;
          phase_d = PH_EXT;
        end
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
      status_d    = emit_st;
      size_d      = emit_size;
      olen_d      = OLW'(emit_len);
      phase_d     = PH_IDLE;
      cnt_d       = '0;
      acc_d       = '0;
      len_d       = '0;
      look_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      len_q       <= '0;
      look_q      <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= cslp_pkg::ST_DATA;
      size_q      <= '0;
      olen_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      look_q      <= look_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      size_q      <= size_d;
      olen_q      <= olen_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign chunk_size_o  = size_q;
  assign line_length_o = olen_q;

endmodule

// File: hdl/chunked_size_line_parser_core.sv
// Result path: classified bytes pass through the queue, and each result item is held in the output register.
// Throughput: one byte per cycle unless the queue is full; the classifier queue and
// the output register let an output stall hold the input only once the queue is full.
// Reset: rst_ni is asynchronous and active low; it empties the queue, drops any pending
// result and returns the parser to idle with all counters and the size cleared.
`include "chunked_size_line_parser_core_defines.svh"

module chunked_size_line_parser_core #(
  parameter int unsigned MAX_SIZE_DIGITS = cslp_pkg::MAX_SIZE_DIGITS_DEF,
  parameter int unsigned LENGTH_BITS     = cslp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = cslp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cslp_pkg::STATUS_W-1:0]   status_o,
  output logic [cslp_pkg::SIZE_W-1:0]     chunk_size_o,
  output logic [cslp_pkg::LINE_LEN_W-1:0] line_length_o
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  cslp_pkg::tok_t tok_in;
  cslp_pkg::tok_t tok_out;

  cslp_front u_front (
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .tok_o      (tok_in)
  );

  cslp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .tok_o   (tok_out)
  );

  cslp_back #(
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (q_valid),
    .tok_i         (tok_out),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .chunk_size_o  (chunk_size_o),
    .line_length_o (line_length_o)
  );

  `CSLP_ASSERT_IMPLIES(a_failed_zero, clk_i, rst_ni,
                       out_valid_o && status_o == cslp_pkg::ST_FAILED,
                       chunk_size_o == '0 && line_length_o == '0,
                       "failed item carries nonzero fields")
  `CSLP_ASSERT_IMPLIES(a_data_nonzero, clk_i, rst_ni,
                       out_valid_o && status_o == cslp_pkg::ST_DATA,
                       chunk_size_o != '0,
                       "data item with zero size")
  `CSLP_ASSERT_IMPLIES(a_final_len, clk_i, rst_ni,
                       out_valid_o && status_o == cslp_pkg::ST_FINAL,
                       chunk_size_o == '0 && line_length_o >= 16'd5,
                       "final item with bad fields")
  `CSLP_ASSERT_ALWAYS(a_stall_has_work, clk_i, rst_ni,
                      !in_stall_o || q_valid,
                      "input stalled with empty queue")

endmodule
